/* hdl/rrjs_pkg.sv */
// ----------------------------------------------------------------------------
// rrjs_pkg
// Shared types and constants of the round-robin job scheduler.
// ----------------------------------------------------------------------------
package rrjs_pkg;

	// configuration register indexes
	localparam int REG_IDX_W       = 1;
	localparam logic [REG_IDX_W-1:0] REG_SCHED_MODE = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_QUANTUM    = 1'd1;

	localparam int CFG_DATA_W = 8;
	localparam int FIELD_W    = 8;   // width of the size and slice fields
	localparam int TIME_W     = 16;

	localparam logic                  MODE_RESET    = 1'b0;
	localparam logic [FIELD_W-1:0]    QUANTUM_RESET = 8'd6;
	localparam logic                  MODE_RR       = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic accept;    // latch an arrival and push it
		logic rd_head;   // read the head entry
		logic dispatch;  // run the head job and load the result
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;  // result register holds a beat not taken this cycle
	} dp_status_t;

endpackage

/* hdl/rrjs_ctrl.sv */
// ----------------------------------------------------------------------------
// rrjs_ctrl
// Step sequencer: accept, head read, dispatch.
// ----------------------------------------------------------------------------
module rrjs_ctrl
	import rrjs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DISP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.rd_head  = 1'b0;
		cmd.dispatch = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_head = 1'b1;
				state_d     = ST_DISP;
			end
			ST_DISP: begin
				// hold until the result register can take the beat
				if (!status.out_busy) begin
					cmd.dispatch = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/rrjs_datapath.sv */
// ----------------------------------------------------------------------------
// rrjs_datapath
// Job queue memory, pointers, time counter, config and result register.
// ----------------------------------------------------------------------------
module rrjs_datapath
	import rrjs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int SIZE_BITS   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	input  logic                  cfg_wr_en,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  arrive_valid,
	input  logic [FIELD_W-1:0]    arrive_size,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  ran_valid,
	output logic [TIME_W-1:0]     ran_id,
	output logic [FIELD_W-1:0]    ran_size,
	output logic [FIELD_W-1:0]    slice_time,
	output logic                  requeued,
	output logic [TIME_W-1:0]     time_now,
	output logic                  arrival_dropped
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (SIZE_BITS > FIELD_W) ? SIZE_BITS : FIELD_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	logic [TIME_W-1:0]    mem_id   [QUEUE_DEPTH];
	logic [SIZE_BITS-1:0] mem_size [QUEUE_DEPTH];

	logic [PTR_W-1:0]     head_q, tail_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_W-1:0]    time_q;
	logic                 mode_q;
	logic [FIELD_W-1:0]   quantum_q;
	logic                 drop_q;
	logic [TIME_W-1:0]    rd_id_q;
	logic [SIZE_BITS-1:0] rd_size_q;
	logic                 out_valid_q;

	logic                 wr_en;
	logic [TIME_W-1:0]    wr_id;
	logic [SIZE_BITS-1:0] wr_size;
	logic                 push_arrival;
	logic                 has_job;
	logic [CMP_W-1:0]     size_ext, quantum_ext, slice_c;
	logic                 do_requeue;

	assign push_arrival = cmd.accept && arrive_valid && (count_q != CNT_FULL);
	assign has_job      = (count_q != '0);

	assign size_ext    = CMP_W'(rd_size_q);
	assign quantum_ext = CMP_W'(quantum_q);
	assign do_requeue  = (mode_q == MODE_RR) && (size_ext > quantum_ext);
	assign slice_c     = do_requeue ? quantum_ext : size_ext;

	// one write port: arrival at accept, requeue at dispatch
	always_comb begin
		wr_en   = 1'b0;
		wr_id   = time_q;
		wr_size = SIZE_BITS'(arrive_size);
		if (push_arrival) begin
			wr_en = 1'b1;
		end else if (cmd.dispatch && has_job && do_requeue) begin
			wr_en   = 1'b1;
			wr_id   = rd_id_q;
			wr_size = SIZE_BITS'(size_ext - quantum_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_id[tail_q]   <= wr_id;
			mem_size[tail_q] <= wr_size;
		end
		if (cmd.rd_head) begin
			rd_id_q   <= mem_id[head_q];
			rd_size_q <= mem_size[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			time_q    <= '0;
			mode_q    <= MODE_RESET;
			quantum_q <= QUANTUM_RESET;
			drop_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_SCHED_MODE: mode_q    <= cfg_data[0];
					REG_QUANTUM:    quantum_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				drop_q <= arrive_valid && (count_q == CNT_FULL);
				if (push_arrival) begin
					tail_q  <= ptr_inc(tail_q);
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.dispatch && has_job) begin
				head_q <= ptr_inc(head_q);
				time_q <= time_q + TIME_W'(slice_c);
				if (do_requeue) begin
					tail_q <= ptr_inc(tail_q);
				end else begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.dispatch) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dispatch) begin
			ran_valid       <= has_job;
			ran_id          <= has_job ? rd_id_q : '0;
			ran_size        <= has_job ? FIELD_W'(size_ext) : '0;
			slice_time      <= has_job ? FIELD_W'(slice_c) : '0;
			requeued        <= has_job && do_requeue;
			time_now        <= has_job ? time_q + TIME_W'(slice_c) : time_q;
			arrival_dropped <= drop_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_busy = out_valid_q && !out_ready;

endmodule

/* hdl/round_robin_job_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// round_robin_job_scheduler_unit
// Job scheduler with a FIFO of pending jobs, first-come or round-robin.
// ----------------------------------------------------------------------------
// Each input beat is one scheduling step and gives exactly one result beat.
// A step runs in order: the arrival is written into the job queue, the head
// entry is read from the queue memory (registered read), then the job is
// dispatched and a requeue, if any, goes back through the single write port.
// A new step is accepted only after the previous one has been dispatched;
// if the previous result has not been taken, dispatch waits for it. The queue
// needs no clearing after reset. A config write lands at the edge it is given
// on, so config must be written only between steps.
module round_robin_job_scheduler_unit
	import rrjs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int SIZE_BITS   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  arrive_valid,
	input  logic [FIELD_W-1:0]    arrive_size,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  ran_valid,
	output logic [TIME_W-1:0]     ran_id,
	output logic [FIELD_W-1:0]    ran_size,
	output logic [FIELD_W-1:0]    slice_time,
	output logic                  requeued,
	output logic [TIME_W-1:0]     time_now,
	output logic                  arrival_dropped
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	rrjs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rrjs_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.SIZE_BITS   (SIZE_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.arrive_valid    (arrive_valid),
		.arrive_size     (arrive_size),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ran_valid       (ran_valid),
		.ran_id          (ran_id),
		.ran_size        (ran_size),
		.slice_time      (slice_time),
		.requeued        (requeued),
		.time_now        (time_now),
		.arrival_dropped (arrival_dropped)
	);

endmodule

/* test/round_robin_job_scheduler_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_job_scheduler_unit_test
// Self-checking bench for the job scheduler. Steps go in through the input
// channel. A local scheduler model predicts each dispatch beat. Beats are
// checked field by field in order, under several mode and quantum settings
// and three sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module round_robin_job_scheduler_unit_test;
	import rrjs_pkg::*;

	localparam int JOB_SLOTS = 16;

	typedef struct {
		logic [TIME_W-1:0]  id;
		logic [FIELD_W-1:0] size;
	} job_t;

	typedef struct {
		logic               ran_valid;
		logic [TIME_W-1:0]  ran_id;
		logic [FIELD_W-1:0] ran_size;
		logic [FIELD_W-1:0] slice_time;
		logic               requeued;
		logic [TIME_W-1:0]  time_now;
		logic               arrival_dropped;
	} dispatch_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  arrive_valid = 1'b0;
	logic [FIELD_W-1:0]    arrive_size = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  ran_valid;
	logic [TIME_W-1:0]     ran_id;
	logic [FIELD_W-1:0]    ran_size;
	logic [FIELD_W-1:0]    slice_time;
	logic                  requeued;
	logic [TIME_W-1:0]     time_now;
	logic                  arrival_dropped;

	// scheduler model state
	job_t               pending_jobs[$];
	logic [TIME_W-1:0]  sched_clock = '0;
	logic               cur_mode = MODE_RESET;
	logic [FIELD_W-1:0] cur_quantum = QUANTUM_RESET;

	dispatch_t expected_dispatch[$];
	int        err_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;

	round_robin_job_scheduler_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.arrive_valid    (arrive_valid),
		.arrive_size     (arrive_size),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ran_valid       (ran_valid),
		.ran_id          (ran_id),
		.ran_size        (ran_size),
		.slice_time      (slice_time),
		.requeued        (requeued),
		.time_now        (time_now),
		.arrival_dropped (arrival_dropped)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// one scheduling step: enqueue the arrival, dispatch the head, maybe requeue
	function automatic dispatch_t schedule_step(input logic av, input logic [FIELD_W-1:0] sz);
		dispatch_t r;
		job_t      j;
		r = '{default: '0};
		if (av) begin
			if (pending_jobs.size() >= JOB_SLOTS) begin
				r.arrival_dropped = 1'b1;
			end else begin
				j.id = sched_clock;
				j.size = sz;
				pending_jobs.push_back(j);
			end
		end
		if (pending_jobs.size() > 0) begin
			j = pending_jobs.pop_front();
			r.ran_valid = 1'b1;
			r.ran_id = j.id;
			r.ran_size = j.size;
			if (cur_mode == MODE_RR && j.size > cur_quantum) begin
				r.slice_time = cur_quantum;
				r.requeued = 1'b1;
				j.size = j.size - cur_quantum;
				pending_jobs.push_back(j);
			end else begin
				r.slice_time = j.size;
			end
			sched_clock = sched_clock + TIME_W'(r.slice_time);
		end
		r.time_now = sched_clock;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	task automatic check_dispatch(input dispatch_t got);
		dispatch_t want;
		if (expected_dispatch.size() == 0) begin
			report_mismatch("unexpected beat", 1, 0);
		end else begin
			want = expected_dispatch.pop_front();
			if (got.ran_valid !== want.ran_valid)
				report_mismatch("ran_valid", got.ran_valid, want.ran_valid);
			if (got.ran_id !== want.ran_id)
				report_mismatch("ran_id", got.ran_id, want.ran_id);
			if (got.ran_size !== want.ran_size)
				report_mismatch("ran_size", got.ran_size, want.ran_size);
			if (got.slice_time !== want.slice_time)
				report_mismatch("slice_time", got.slice_time, want.slice_time);
			if (got.requeued !== want.requeued)
				report_mismatch("requeued", got.requeued, want.requeued);
			if (got.time_now !== want.time_now)
				report_mismatch("time_now", got.time_now, want.time_now);
			if (got.arrival_dropped !== want.arrival_dropped)
				report_mismatch("arrival_dropped", got.arrival_dropped, want.arrival_dropped);
		end
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			check_dispatch('{ran_valid, ran_id, ran_size, slice_time, requeued, time_now,
				arrival_dropped});
		end
	end

	// valid stays high across back-to-back beats; it only drops on a sender gap
	task automatic send_step(input logic av, input logic [FIELD_W-1:0] sz);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			arrive_valid <= 1'($urandom_range(1));
			arrive_size <= FIELD_W'($urandom_range(255));
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		arrive_valid <= av;
		arrive_size <= sz;
		do @(posedge clk); while (in_ready !== 1'b1);
		expected_dispatch.push_back(schedule_step(av, sz));
	endtask

	// drop valid and let the block go quiet before touching registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_dispatch.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_SCHED_MODE)
			cur_mode = val[0];
		else
			cur_quantum = val;
	endtask

	// empty queue, zero and extreme sizes, arrival into an empty queue
	task automatic test_empty_and_sizes();
		send_step(1'b0, 8'd0);
		send_step(1'b1, 8'd0);
		send_step(1'b1, 8'd255);
		send_step(1'b1, 8'd1);
		send_step(1'b0, 8'd170);
		send_step(1'b1, 8'd85);
		settle();
	endtask

	// zero quantum leaves the job unchanged, widest quantum runs it out
	task automatic test_zero_quantum();
		write_reg(REG_SCHED_MODE, CFG_DATA_W'(MODE_RR));
		write_reg(REG_QUANTUM, 8'd0);
		send_step(1'b1, 8'd5);
		send_step(1'b0, 8'd0);
		settle();
		write_reg(REG_QUANTUM, 8'd255);
		send_step(1'b0, 8'd0);
		send_step(1'b1, 8'd255);
		settle();
	endtask

	// quantum 1 keeps every long job queued, so arrivals pile up until dropped
	task automatic test_queue_full();
		write_reg(REG_QUANTUM, 8'd1);
		for (int i = 0; i < JOB_SLOTS + 2; i++)
			send_step(1'b1, 8'd255);
		settle();
	endtask

	function automatic logic [FIELD_W-1:0] pick_size(input logic [FIELD_W-1:0] q);
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(2))
					0: return 8'd0;
					1: return 8'd1;
					default: return 8'd255;
				endcase
			end
			1: return q;
			2: return q + 8'd1;
			3: return FIELD_W'($urandom_range(255));
			default: return FIELD_W'($urandom_range(1, 24));
		endcase
	endfunction

	task automatic test_random_mix(input int per_setting);
		logic               mode;
		logic [FIELD_W-1:0] q;
		int                 arrive_pct;
		for (int s = 0; s < 4; s++) begin
			case (s)
				0: begin mode = MODE_RR; q = 8'd1; arrive_pct = 95; end
				1: begin mode = ~MODE_RR; q = FIELD_W'($urandom_range(1, 255));
					arrive_pct = $urandom_range(20, 90); end
				2: begin mode = MODE_RR; q = 8'd255; arrive_pct = 95; end
				default: begin mode = MODE_RR; q = FIELD_W'($urandom_range(2, 20));
					arrive_pct = $urandom_range(20, 90); end
			endcase
			settle();
			write_reg(REG_SCHED_MODE, CFG_DATA_W'(mode));
			write_reg(REG_QUANTUM, q);
			for (int i = 0; i < per_setting; i++)
				send_step($urandom_range(99) < arrive_pct, pick_size(q));
		end
		settle();
	endtask

	task automatic finish_run();
		@(negedge clk);
		in_valid <= 1'b0;
		for (int w = 0; w < 100000 && expected_dispatch.size() != 0; w++)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (expected_dispatch.size() != 0)
			report_mismatch("beats outstanding", 0, expected_dispatch.size());
		if (err_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 85;
		test_empty_and_sizes();
		test_zero_quantum();
		test_queue_full();
		test_random_mix(85);

		send_idle_pct = 85;
		recv_idle_pct = 18;
		test_random_mix(85);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(85);

		finish_run();
	end

endmodule
